>>> rtl/homogeneous_transform_unit_defines.svh
// assertion macros for the homogeneous transform unit
// used by the port checker; no other dependencies
`ifndef HOMOGENEOUS_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_TRANSFORM_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define HTU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("htu assertion failed");

// consequent checked in the next cycle
`define HTU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("htu assertion failed");

`endif

>>> rtl/htu_pkg.sv
// shared types and constants for the homogeneous transform unit
// no dependencies
package htu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  // width of the exact dot-product sums, holds any fraction width from 8 to 24
  localparam int unsigned SUM_W = 68;
  // quotient bits produced by the divider lanes
  localparam int unsigned QBITS = 32;
  localparam int unsigned LANE_STAGES = QBITS + 1;

  typedef enum logic [2:0] {
    OP_POINT     = 3'd0,
    OP_INV_POINT = 3'd1,
    OP_DIR       = 3'd2,
    OP_INV_DIR   = 3'd3,
    OP_NORMAL    = 3'd4,
    OP_LOAD      = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic [4:0]         load_index;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divide_by_zero;
    logic               saturated;
  } out_item_t;

endpackage

>>> rtl/htu_div_lane.sv
// pipelined restoring divider lane, one quotient bit per stage
// depends on htu_pkg
module htu_div_lane #(
  parameter int unsigned FRAC_BITS = htu_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [htu_pkg::SUM_W-1:0]  num_i,
  input  logic [htu_pkg::SUM_W-1:0]  den_i,
  output logic                       big_o,
  output logic [htu_pkg::QBITS-1:0]  quo_o
);
  import htu_pkg::*;

  localparam int unsigned DdW = SUM_W + FRAC_BITS;
  localparam int unsigned HiW = DdW - QBITS;

  logic [DdW-1:0] dd;
  logic [HiW-1:0] dhi;

  logic [SUM_W-1:0] r_q   [QBITS+1];
  logic [QBITS-1:0] lo_q  [QBITS+1];
  logic [QBITS-1:0] q_q   [QBITS+1];
  logic [SUM_W-1:0] d_q   [QBITS+1];
  logic             big_q [QBITS+1];

  // dividend is num scaled by the fraction width
  assign dd  = {num_i, {FRAC_BITS{1'b0}}};
  assign dhi = dd[DdW-1:QBITS];

  // quotient of 2^32 or more always clips
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= SUM_W'(dhi);
      lo_q[0]  <= dd[QBITS-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= den_i;
      big_q[0] <= (SUM_W'(dhi) >= den_i);
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_step
    logic [SUM_W:0] t;
    logic [SUM_W:0] diff;
    logic           take;

    assign t    = {r_q[j], lo_q[j][QBITS-1]};
    assign diff = t - {1'b0, d_q[j]};
    assign take = (t >= {1'b0, d_q[j]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]   <= take ? diff[SUM_W-1:0] : t[SUM_W-1:0];
        lo_q[j+1]  <= lo_q[j] << 1;
        q_q[j+1]   <= {q_q[j][QBITS-2:0], take};
        d_q[j+1]   <= d_q[j];
        big_q[j+1] <= big_q[j];
      end
    end
  end

  assign big_o = big_q[QBITS];
  assign quo_o = q_q[QBITS];

endmodule

>>> rtl/homogeneous_transform_unit.sv
// top level of the homogeneous 4x4 point transform unit
// depends on htu_pkg and htu_div_lane
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | inbound   | in_valid_i / in_stall_o  | htu_pkg::in_item_t
//  out     | outbound  | out_valid_o / out_stall_i| htu_pkg::out_item_t
//
// one item enters per cycle while the input is not stalled; a transform passes
// stages a to e, then the divider lanes with their 32 one-bit stages, to the output
// loads write the matrix store at acceptance and give no result
// reset clears the matrix store to zero and empties the pipeline at once
// a two-entry output buffer takes results; only when it holds two does the
// whole pipeline hold and the input stall
module homogeneous_transform_unit #(
  parameter int unsigned FRAC_BITS = htu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  htu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htu_pkg::out_item_t out_item_o
);
  import htu_pkg::*;

  localparam int unsigned NST = 5 + LANE_STAGES;
  localparam logic [SUM_W-1:0] RoundC = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [31:0] PosMax = 32'h7fff_ffff;
  localparam logic [31:0] NegMin = 32'h8000_0000;

  // control that travels alongside the divider lanes
  typedef struct packed {
    logic             is_pt;
    logic             wzero;
    logic [2:0]       neg;
    logic [2:0][31:0] res;
    logic             sat;
  } ctl_t;

  // global advance, held only when the output buffer is full
  logic en;
  logic [NST-1:0] vld_q;

  // decode
  logic is_xform, is_load, is_pt, sel_inv, sel_t;

  always_comb begin
    is_xform = 1'b1;
    is_load  = 1'b0;
    is_pt    = 1'b0;
    sel_inv  = 1'b0;
    sel_t    = 1'b0;
    unique case (op_e'(in_item_i.opcode))
      OP_POINT:     is_pt = 1'b1;
      OP_INV_POINT: begin
        is_pt   = 1'b1;
        sel_inv = 1'b1;
      end
      OP_DIR:       is_pt = 1'b0;
      OP_INV_DIR:   sel_inv = 1'b1;
      OP_NORMAL:    sel_t = 1'b1;
      OP_LOAD: begin
        is_xform = 1'b0;
        is_load  = 1'b1;
      end
      default:      is_xform = 1'b0;
    endcase
  end

  // matrix store: forward in words 0-15, inverse in 16-31, row-major
  logic signed [31:0] mat_q [32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) mat_q[i] <= '0;
    end else if (in_valid_i && en && is_load) begin
      mat_q[in_item_i.load_index] <= in_item_i.load_value;
    end
  end

  // pick the matrix words for this item; direction and normal have no w row
  logic signed [31:0] m_d [4][3];
  logic signed [31:0] b_d [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int unsigned IFwd = r * 4 + c;
      localparam int unsigned IInv = 16 + r * 4 + c;
      localparam int unsigned ITr  = 16 + c * 4 + r;
      always_comb begin
        if (!is_pt && r == 3) m_d[r][c] = '0;
        else if (sel_t)       m_d[r][c] = mat_q[ITr];
        else if (sel_inv)     m_d[r][c] = mat_q[IInv];
        else                  m_d[r][c] = mat_q[IFwd];
      end
    end
    localparam int unsigned BFwd = r * 4 + 3;
    localparam int unsigned BInv = 16 + r * 4 + 3;
    always_comb begin
      if (!is_pt)       b_d[r] = '0;
      else if (sel_inv) b_d[r] = mat_q[BInv];
      else              b_d[r] = mat_q[BFwd];
    end
  end

  // stage a: operands
  logic               a_pt_q;
  logic signed [31:0] a_v_q [3];
  logic signed [31:0] a_m_q [4][3];
  logic signed [31:0] a_b_q [4];
  // stage b: products
  logic               b_pt_q;
  logic signed [63:0] b_p_q [4][3];
  logic signed [31:0] b_b_q [4];
  // stage c: exact sums with rounding term
  logic                   c_pt_q;
  logic signed [SUM_W-1:0] c_s_q [4];
  logic signed [31:0]     c_b_q [4];
  // stage d: rounded dot products
  logic                   d_pt_q;
  logic signed [SUM_W-1:0] d_dot_q [4];
  // stage e: divider operands and control
  logic [SUM_W-1:0] e_n_q [3];
  logic [SUM_W-1:0] e_d_q;
  ctl_t             ctl_q [LANE_STAGES+1];

  logic signed [SUM_W-1:0] c_s_d   [4];
  logic signed [SUM_W-1:0] d_dot_d [4];
  logic [SUM_W-1:0]        e_n_d   [3];
  logic [SUM_W-1:0]        e_d_d;
  ctl_t                    e_ctl_d;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      c_s_d[r] = SUM_W'(b_p_q[r][0]) + SUM_W'(b_p_q[r][1]) + SUM_W'(b_p_q[r][2])
                 + $signed(RoundC);
      d_dot_d[r] = (c_s_q[r] >>> FRAC_BITS) + SUM_W'(c_b_q[r]);
    end
  end

  // magnitudes and signs for the division, clipping for the other ops
  always_comb begin
    e_ctl_d       = '0;
    e_ctl_d.is_pt = d_pt_q;
    e_ctl_d.wzero = d_pt_q && (d_dot_q[3] == '0);
    e_d_d = d_dot_q[3][SUM_W-1] ? ('0 - d_dot_q[3]) : d_dot_q[3];
    for (int r = 0; r < 3; r++) begin
      e_n_d[r] = d_dot_q[r][SUM_W-1] ? ('0 - d_dot_q[r]) : d_dot_q[r];
      // w sign only matters when w is not zero
      e_ctl_d.neg[r] = d_dot_q[r][SUM_W-1] ^ (d_dot_q[3][SUM_W-1] && !e_ctl_d.wzero);
      if ((&d_dot_q[r][SUM_W-1:31]) || !(|d_dot_q[r][SUM_W-1:31])) begin
        e_ctl_d.res[r] = d_dot_q[r][31:0];
      end else begin
        e_ctl_d.res[r] = d_dot_q[r][SUM_W-1] ? NegMin : PosMax;
        e_ctl_d.sat    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pt_q   <= is_pt;
      a_v_q[0] <= in_item_i.in_x;
      a_v_q[1] <= in_item_i.in_y;
      a_v_q[2] <= in_item_i.in_z;
      a_m_q    <= m_d;
      a_b_q    <= b_d;
      b_pt_q   <= a_pt_q;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) b_p_q[r][c] <= a_v_q[c] * a_m_q[r][c];
      end
      b_b_q    <= a_b_q;
      c_pt_q   <= b_pt_q;
      c_s_q    <= c_s_d;
      c_b_q    <= b_b_q;
      d_pt_q   <= c_pt_q;
      d_dot_q  <= d_dot_d;
      e_n_q    <= e_n_d;
      e_d_q    <= e_d_d;
      ctl_q[0] <= e_ctl_d;
      for (int k = 1; k <= LANE_STAGES; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i && is_xform};
    end
  end

  // one divider lane per component, all sharing |w|
  logic             big   [3];
  logic [QBITS-1:0] quo   [3];

  for (genvar r = 0; r < 3; r++) begin : g_lane
    htu_div_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (e_n_q[r]),
      .den_i (e_d_q),
      .big_o (big[r]),
      .quo_o (quo[r])
    );
  end

  // final sign and clip
  ctl_t       fc;
  out_item_t  fin;
  logic [2:0] clip;
  logic [2:0][31:0] val;

  assign fc = ctl_q[LANE_STAGES];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip[r] = 1'b0;
      if (!fc.is_pt) begin
        val[r] = fc.res[r];
      end else if (fc.wzero) begin
        val[r]  = fc.neg[r] ? NegMin : PosMax;
        clip[r] = 1'b1;
      end else if (!fc.neg[r]) begin
        if (big[r] || quo[r][31]) begin
          val[r]  = PosMax;
          clip[r] = 1'b1;
        end else begin
          val[r] = quo[r];
        end
      end else begin
        // minus 2^31 is still representable
        if (big[r] || (quo[r][31] && (|quo[r][30:0]))) begin
          val[r]  = NegMin;
          clip[r] = 1'b1;
        end else begin
          val[r] = '0 - quo[r];
        end
      end
    end
    fin.out_x          = val[0];
    fin.out_y          = val[1];
    fin.out_z          = val[2];
    fin.divide_by_zero = fc.is_pt && fc.wzero;
    fin.saturated      = fc.is_pt ? (|clip) : fc.sat;
  end

  // two-entry output buffer
  out_item_t  buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign en    = (cnt_q != 2'd2);
  assign push  = en && vld_q[NST-1];
  assign pop   = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = buf_q[rd_q];

endmodule

>>> rtl/htu_checker.sv
// port-level checker for the homogeneous transform unit, bound to the top
// depends on htu_pkg and homogeneous_transform_unit_defines.svh
`include "homogeneous_transform_unit_defines.svh"

module htu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input htu_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input htu_pkg::out_item_t out_item_o
);
  import htu_pkg::*;

  `HTU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `HTU_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o))
  `HTU_ASSERT_NOW(a_dz_sat, clk_i, rst_ni, out_valid_o && out_item_o.divide_by_zero, out_item_o.saturated)
  `HTU_ASSERT_NOW(a_dz_rail, clk_i, rst_ni, out_valid_o && out_item_o.divide_by_zero, (out_item_o.out_x == 32'sh7fff_ffff) || (out_item_o.out_x == 32'sh8000_0000))
  `HTU_ASSERT_NOW(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind homogeneous_transform_unit htu_checker u_htu_checker (.*);

>>> tb/sv/htu_scoreboard.sv
// checker for the homogeneous transform unit: watches both channels, predicts
// each transform from its own copy of the matrix store and compares results
// depends on htu_pkg
module htu_scoreboard #(
  parameter int unsigned FRAC_BITS = htu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  htu_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  htu_pkg::out_item_t out_item_i,
  output int                 mismatch_count_o,
  output int                 pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import htu_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic [31:0] matrix_words [32];
  out_item_t   awaited_results [$];

  function automatic wide_t word_at(int idx);
    return wide_t'($signed(matrix_words[idx]));
  endfunction

  // exact dot product plus fixed-point bias, rounded half up
  function automatic wide_t rounded_dot(wide_t v [3], wide_t r [3], wide_t bias);
    wide_t acc;
    acc = bias <<< FRAC_BITS;
    for (int k = 0; k < 3; k++) acc += v[k] * r[k];
    return (acc + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] clip32(wide_t v, ref logic flag);
    if (v > wide_t'(32'sh7fffffff)) begin
      flag = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -wide_t'(64'sh80000000)) begin
      flag = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t transform_vector(in_item_t it);
    out_item_t res;
    wide_t     v [3];
    wide_t     r [3];
    wide_t     sums [4];
    logic      sat;
    int        base;
    logic [31:0] comp [3];
    sat  = 1'b0;
    v[0] = wide_t'(it.in_x);
    v[1] = wide_t'(it.in_y);
    v[2] = wide_t'(it.in_z);
    base = (it.opcode == OP_POINT || it.opcode == OP_DIR) ? 0 : 16;
    res.divide_by_zero = 1'b0;
    if (it.opcode == OP_POINT || it.opcode == OP_INV_POINT) begin
      for (int row = 0; row < 4; row++) begin
        for (int c = 0; c < 3; c++) r[c] = word_at(base + row * 4 + c);
        sums[row] = rounded_dot(v, r, word_at(base + row * 4 + 3));
      end
      if (sums[3] == 0) begin
        // w of zero: every component pinned by the sign of its sum
        res.divide_by_zero = 1'b1;
        sat = 1'b1;
        for (int row = 0; row < 3; row++)
          comp[row] = (sums[row] < 0) ? 32'h80000000 : 32'h7fffffff;
      end else begin
        for (int row = 0; row < 3; row++)
          comp[row] = clip32((sums[row] <<< FRAC_BITS) / sums[3], sat);
      end
    end else begin
      for (int row = 0; row < 3; row++) begin
        for (int c = 0; c < 3; c++)
          r[c] = (it.opcode == OP_NORMAL) ? word_at(base + c * 4 + row)
                                          : word_at(base + row * 4 + c);
        comp[row] = clip32(rounded_dot(v, r, 0), sat);
      end
    end
    res.out_x = comp[0];
    res.out_y = comp[1];
    res.out_z = comp[2];
    res.saturated = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) matrix_words[i] = '0;
      awaited_results.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transform outstanding");
          mismatch_count_o++;
        end else begin
          out_item_t want;
          want = awaited_results.pop_front();
          if (want.out_x !== out_item_i.out_x) begin
            $error("out_x expected %h got %h", want.out_x, out_item_i.out_x);
            mismatch_count_o++;
          end
          if (want.out_y !== out_item_i.out_y) begin
            $error("out_y expected %h got %h", want.out_y, out_item_i.out_y);
            mismatch_count_o++;
          end
          if (want.out_z !== out_item_i.out_z) begin
            $error("out_z expected %h got %h", want.out_z, out_item_i.out_z);
            mismatch_count_o++;
          end
          if (want.divide_by_zero !== out_item_i.divide_by_zero) begin
            $error("divide_by_zero expected %b got %b", want.divide_by_zero,
                   out_item_i.divide_by_zero);
            mismatch_count_o++;
          end
          if (want.saturated !== out_item_i.saturated) begin
            $error("saturated expected %b got %b", want.saturated,
                   out_item_i.saturated);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.opcode == OP_LOAD)
          matrix_words[in_item_i.load_index] = in_item_i.load_value;
        else if (in_item_i.opcode < OP_LOAD)
          awaited_results.push_back(transform_vector(in_item_i));
      end
    end
    pending_count_o = awaited_results.size();
  end

endmodule

>>> tb/sv/homogeneous_transform_unit_test.sv
// top of the homogeneous transform unit testbench: clock, reset, stimulus,
// random idling on both channels and the verdict
// depends on htu_pkg, homogeneous_transform_unit and htu_scoreboard
module homogeneous_transform_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import htu_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 60;  // extra wait, longer than the transform pipeline

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  int        mismatch_count;
  int        pending_count;
  int        cycle_count;
  logic      hold_receiver;  // asks the receiver for one long stall

  homogeneous_transform_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  htu_scoreboard checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_i      (out_item_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  // free-running clock, 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // watchdog on a plain cycle count
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small values in q16.16 (within plus or minus 64) most of the time, rails or full range otherwise
  function automatic logic [31:0] fixed_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return 32'($signed($urandom_range(0, 32'h7fffff)) - 32'sh400000);
    endcase
  endfunction

  // receiver side: random stalls with stall-free stretches, plus one long hold when asked
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall_i    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_receiver && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall_i = 1'b1;
        repeat (150) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (cycle_count % 2000 < 300) begin
        out_stall_i = 1'b0;  // stretch with no stalls
      end else begin
        out_stall_i = ($urandom_range(0, 99) < 25);
        if (out_stall_i && $urandom_range(0, 9) == 0)
          repeat ($urandom_range(5, 30)) @(negedge clk_i);
      end
    end
  end

  // one item offered at a falling edge and held until taken
  task automatic offer_item(input in_item_t it);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      in_item_i  = '0;
    end
  endtask

  task automatic send_vector(input op_e op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    in_item_t it;
    it            = '0;
    it.opcode     = op;
    it.in_x       = x;
    it.in_y       = y;
    it.in_z       = z;
    it.load_index = 5'($urandom);  // ignored field, exercised anyway
    it.load_value = $urandom;
    offer_item(it);
  endtask

  task automatic load_word(input logic [4:0] idx, input logic [31:0] val);
    in_item_t it;
    it            = '0;
    it.opcode     = OP_LOAD;
    it.in_x       = $urandom;
    it.in_y       = $urandom;
    it.in_z       = $urandom;
    it.load_index = idx;
    it.load_value = val;
    offer_item(it);
  endtask

  task automatic wait_until_drained();
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    in_item_t it;
    op_e      op;
    int       gap;
    cycle_count   = 0;
    hold_receiver = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero store after reset gives w of zero on points
    send_vector(OP_POINT, 32'h00010000, 32'hffff0000, 32'h0);
    send_vector(OP_INV_POINT, 32'h7fffffff, 32'h80000000, 32'h1);
    send_vector(OP_DIR, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    // identity forward, a scaled inverse with translation
    for (int i = 0; i < 16; i++)
      load_word(5'(i), (i % 5 == 0) ? 32'h00010000 : 32'h0);
    load_word(5'd16, 32'h7fffffff);
    load_word(5'd21, 32'h80000000);
    load_word(5'd26, 32'h00020000);
    load_word(5'd19, 32'hffffffff);
    load_word(5'd31, 32'h00010000);
    send_vector(OP_POINT, 32'h7fffffff, 32'h80000000, 32'h00018000);
    send_vector(OP_INV_POINT, 32'h00020000, 32'h00020000, 32'hfffe0000);
    send_vector(OP_INV_DIR, 32'h7fffffff, 32'h80000000, 32'h0);
    send_vector(OP_NORMAL, 32'h80000000, 32'h80000000, 32'h80000000);
    send_vector(OP_NORMAL, 32'h00000001, 32'hffffffff, 32'h00008000);
    idle_sender(1);
    wait_until_drained();

    // random: about one item in ten reloads a matrix word, the rest are transforms
    for (int n = 0; n < 500; n++) begin
      // sender keeps going with no gaps while the receiver holds off
      if (n == 200) hold_receiver = 1'b1;
      if (n == 260) hold_receiver = 1'b0;
      if (n == 350) begin
        idle_sender(1);
        wait_until_drained();
      end
      if ($urandom_range(0, 9) == 0) begin
        load_word(5'($urandom_range(0, 31)), fixed_value());
      end else begin
        op = op_e'($urandom_range(0, 4));
        send_vector(op, fixed_value(), fixed_value(), fixed_value());
      end
      gap = gap_length();
      if (gap != 0 && (n < 200 || n >= 260)) idle_sender(gap);
    end
    idle_sender(1);
    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
